### hdl/sensor_channel_mean_min_max_macros.svh
// assertion macros for the sensor channel mean/min/max block
`ifndef SENSOR_CHANNEL_MEAN_MIN_MAX_MACROS_SVH
`define SENSOR_CHANNEL_MEAN_MIN_MAX_MACROS_SVH
`ifndef SYNTHESIS
`define SCM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SCM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCM_ASSERT_IMP(name, ante, cons, msg)
`define SCM_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

### hdl/scm_pkg.sv
// shared constants and types of the sensor channel mean/min/max block
package scm_pkg;

  localparam int MAX_SAMPLES_DEF  = 512;
  localparam int MAX_CHANNELS_DEF = 128;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // configuration registers
  localparam int SPC_W  = 10;
  localparam int CC_W   = 8;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [SPC_W-1:0] SPC_RESET = 10'd500;
  localparam logic [CC_W-1:0]  CC_RESET  = 8'd96;

  localparam logic REG_SPC = 1'b0;
  localparam logic REG_CC  = 1'b1;

  // channel jobs waiting between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/scm_channels.sv
// stream interfaces for the sample channel and the result channel
interface scm_in_if #(
  parameter int SAMPLE_WIDTH = scm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface scm_out_if #(
  parameter int SAMPLE_WIDTH = scm_pkg::SAMPLE_WIDTH_DEF,
  parameter int CH_W         = 7
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] frame_average;
  logic signed [SAMPLE_WIDTH-1:0] highest_mean;
  logic        [CH_W-1:0]         highest_channel;
  logic signed [SAMPLE_WIDTH-1:0] lowest_mean;
  logic        [CH_W-1:0]         lowest_channel;

  modport source (output valid, output frame_average, output highest_mean,
                  output highest_channel, output lowest_mean, output lowest_channel,
                  input ready);
  modport sink   (input valid, input frame_average, input highest_mean,
                  input highest_channel, input lowest_mean, input lowest_channel,
                  output ready);
endinterface

### hdl/scm_fifo.sv
// small show-ahead queue of channel jobs between front and back
module scm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = scm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import scm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/scm_div.sv
// bit-serial signed by unsigned divider, truncating toward zero
module scm_div #(
  parameter int DIV_W = 32,
  parameter int DVS_W = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIV_W-1:0]  dividend,
  input  logic        [DVS_W-1:0]  divisor,
  output scm_pkg::div_stat_t       stat,
  output logic signed [DIV_W-1:0]  quotient
);
  import scm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_diff;
  logic             fits;

  // one quotient bit a cycle, dividend bits shift out of the top of quo_r
  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign fits     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      neg_nxt  = dividend[DIV_W-1];
      quo_nxt  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(rem_diff) : DVS_W'(rem_sh);
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

### hdl/scm_front.sv
// front part: accumulates samples and closes channels into jobs
module scm_front #(
  parameter int MAX_SAMPLES  = scm_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CHANNELS = scm_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = scm_pkg::SAMPLE_WIDTH_DEF,
  parameter int JOB_W        = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  scm_in_if.sink                                in_ch,
  input  logic [$clog2(MAX_SAMPLES + 1)-1:0]    ns,
  input  logic [$clog2(MAX_CHANNELS + 1)-1:0]   nc,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [JOB_W-1:0]                      q_data
);
  import scm_pkg::*;

  localparam int SI_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NS_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NC_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CSUM_W = SAMPLE_WIDTH + $clog2(MAX_SAMPLES);

  logic [SI_W-1:0]          sample_idx_r, sample_idx_nxt;
  logic [CH_W-1:0]          chan_idx_r, chan_idx_nxt;
  logic signed [CSUM_W-1:0] csum_r, csum_nxt;
  logic signed [CSUM_W-1:0] sum_add;
  logic                     accept;
  logic                     chan_end;
  logic                     frame_end;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sum_add     = csum_r + CSUM_W'(in_ch.sample);

  // at-or-past compares so a smaller limit written mid-frame closes at once
  assign chan_end  = (NS_W'(sample_idx_r) + NS_W'(1)) >= ns;
  assign frame_end = (NC_W'(chan_idx_r) + NC_W'(1)) >= nc;

  always_comb begin
    sample_idx_nxt = sample_idx_r;
    chan_idx_nxt   = chan_idx_r;
    csum_nxt       = csum_r;
    if (accept) begin
      if (chan_end) begin
        sample_idx_nxt = '0;
        csum_nxt       = '0;
        chan_idx_nxt   = frame_end ? '0 : chan_idx_r + CH_W'(1);
      end else begin
        sample_idx_nxt = sample_idx_r + SI_W'(1);
        csum_nxt       = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_idx_r <= '0;
      chan_idx_r   <= '0;
      csum_r       <= '0;
    end else begin
      sample_idx_r <= sample_idx_nxt;
      chan_idx_r   <= chan_idx_nxt;
      csum_r       <= csum_nxt;
    end
  end

  // job word: last, channel count, sample count, channel index, channel sum
  assign q_push = accept && chan_end;
  assign q_data = JOB_W'({frame_end, nc, ns, chan_idx_r, sum_add});

endmodule

### hdl/scm_back.sv
// back part: divides each channel sum, tracks extremes, emits the frame word
module scm_back #(
  parameter int MAX_SAMPLES  = scm_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CHANNELS = scm_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = scm_pkg::SAMPLE_WIDTH_DEF,
  parameter int JOB_W        = 64,
  parameter int DIV_W        = 32,
  parameter int DVS_W        = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  logic [JOB_W-1:0]         q_data,
  output logic                     q_pop,
  output logic                     div_start,
  output logic signed [DIV_W-1:0]  div_dividend,
  output logic [DVS_W-1:0]         div_divisor,
  input  scm_pkg::div_stat_t       div_stat,
  input  logic signed [DIV_W-1:0]  div_quotient,
  scm_out_if.source                out_ch
);
  import scm_pkg::*;

  localparam int NS_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NC_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CSUM_W = SAMPLE_WIDTH + $clog2(MAX_SAMPLES);
  localparam int FSUM_W = CSUM_W + $clog2(MAX_CHANNELS);

  localparam int CHAN_LSB = CSUM_W;
  localparam int NS_LSB   = CHAN_LSB + CH_W;
  localparam int NC_LSB   = NS_LSB + NS_W;
  localparam int LAST_BIT = NC_LSB + NC_W;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = ~SMP_MIN;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MEAN = 4'b0010,
    B_AVG  = 4'b0100,
    B_PUSH = 4'b1000
  } back_state_t;

  back_state_t              state_r, state_nxt;
  logic                     last_r, last_nxt;
  logic [NC_W-1:0]          nc_r, nc_nxt;
  logic [CH_W-1:0]          chan_r, chan_nxt;
  logic signed [FSUM_W-1:0] fsum_r, fsum_nxt;
  logic signed [CSUM_W-1:0] high_r, high_nxt;
  logic [CH_W-1:0]          high_ch_r, high_ch_nxt;
  logic signed [CSUM_W-1:0] low_r, low_nxt;
  logic [CH_W-1:0]          low_ch_r, low_ch_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] avg_o_r, high_o_r, low_o_r;
  logic [CH_W-1:0]          high_ch_o_r, low_ch_o_r;

  logic signed [CSUM_W-1:0] job_csum;
  logic signed [CSUM_W-1:0] mean;
  logic signed [FSUM_W-1:0] fsum_upd;
  logic                     out_free;
  logic                     load_out;

  assign job_csum = $signed(q_data[CSUM_W-1:0]);
  assign mean     = CSUM_W'(div_quotient);
  assign fsum_upd = fsum_r + FSUM_W'(mean);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    nc_nxt       = nc_r;
    chan_nxt     = chan_r;
    fsum_nxt     = fsum_r;
    high_nxt     = high_r;
    high_ch_nxt  = high_ch_r;
    low_nxt      = low_r;
    low_ch_nxt   = low_ch_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(job_csum);
    div_divisor  = DVS_W'(q_data[NS_LSB +: NS_W]);
    load_out     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          div_start = 1'b1;
          last_nxt  = q_data[LAST_BIT];
          nc_nxt    = q_data[NC_LSB +: NC_W];
          chan_nxt  = q_data[CHAN_LSB +: CH_W];
          state_nxt = B_MEAN;
        end
      end
      B_MEAN: begin
        if (div_stat.done) begin
          fsum_nxt = fsum_upd;
          // strict compares keep the earlier channel on a tie
          if (mean > high_r) begin
            high_nxt    = mean;
            high_ch_nxt = chan_r;
          end
          if (mean < low_r) begin
            low_nxt    = mean;
            low_ch_nxt = chan_r;
          end
          if (last_r) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(fsum_upd);
            div_divisor  = DVS_W'(nc_r);
            state_nxt    = B_AVG;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_AVG: begin
        if (div_stat.done) begin
          state_nxt = B_PUSH;
        end
      end
      B_PUSH: begin
        if (out_free) begin
          load_out    = 1'b1;
          fsum_nxt    = '0;
          high_nxt    = CSUM_W'(SMP_MIN);
          high_ch_nxt = '0;
          low_nxt     = CSUM_W'(SMP_MAX);
          low_ch_nxt  = '0;
          state_nxt   = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      last_r      <= 1'b0;
      fsum_r      <= '0;
      high_r      <= CSUM_W'(SMP_MIN);
      high_ch_r   <= '0;
      low_r       <= CSUM_W'(SMP_MAX);
      low_ch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      fsum_r      <= fsum_nxt;
      high_r      <= high_nxt;
      high_ch_r   <= high_ch_nxt;
      low_r       <= low_nxt;
      low_ch_r    <= low_ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nc_r   <= nc_nxt;
    chan_r <= chan_nxt;
    if (load_out) begin
      avg_o_r     <= SAMPLE_WIDTH'(div_quotient);
      high_o_r    <= SAMPLE_WIDTH'(high_r);
      high_ch_o_r <= high_ch_r;
      low_o_r     <= SAMPLE_WIDTH'(low_r);
      low_ch_o_r  <= low_ch_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_average   = avg_o_r;
  assign out_ch.highest_mean    = high_o_r;
  assign out_ch.highest_channel = high_ch_o_r;
  assign out_ch.lowest_mean     = low_o_r;
  assign out_ch.lowest_channel  = low_ch_o_r;

endmodule

### hdl/sensor_channel_mean_min_max.sv
// top level of the sensor channel mean/min/max block
//
// Samples come in on in_ch, channel-major, one word per accepted handshake.
// Every samples_per_channel words close a channel: its sum goes into a
// four-entry job queue and the back part divides it by the sample count.
// After channel_count channels one result word leaves on out_ch: frame
// average, highest and lowest channel mean with their channel index.
// Throughput: one sample a cycle while the front part has queue room. The
// back part handles one channel job at a time in the bit-serial divider,
// so when channels close faster than the divider finishes their jobs, the
// queue fills and in_ch.ready drops until a job retires.
// The last sample of a frame reaches out_ch only after its channel mean
// and then the frame average have gone through the same divider.
// A result waits in the output register while out_ch is stalled; the back
// part keeps taking jobs until it has the next frame ready for that register.
// Reset (rst_n, synchronous) clears all counters and sums, loads the default
// register values (500 samples, 96 channels) and needs no clearing pass.
// Registers sit on an APB-style port at byte addresses 0 and 4.
`include "sensor_channel_mean_min_max_macros.svh"
module sensor_channel_mean_min_max #(
  parameter int MAX_SAMPLES  = scm_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CHANNELS = scm_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = scm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  scm_in_if.sink                      in_ch,
  scm_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scm_pkg::APB_AW-1:0]  paddr,
  input  logic [scm_pkg::APB_DW-1:0]  pwdata,
  output logic [scm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import scm_pkg::*;

  localparam int NS_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NC_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CSUM_W = SAMPLE_WIDTH + $clog2(MAX_SAMPLES);
  localparam int FSUM_W = CSUM_W + $clog2(MAX_CHANNELS);
  localparam int DIV_W  = FSUM_W;
  localparam int DVS_W  = (NS_W > NC_W) ? NS_W : NC_W;
  localparam int JOB_W  = 1 + NC_W + NS_W + CH_W + CSUM_W;

  logic [SPC_W-1:0] spc_r, spc_nxt;
  logic [CC_W-1:0]  cc_r, cc_nxt;
  logic             cfg_wr;
  logic             reg_sel;
  logic [NS_W-1:0]  ns;
  logic [NC_W-1:0]  nc;

  logic               q_push, q_pop, q_full, q_empty;
  logic [JOB_W-1:0]   q_wr_data, q_rd_data;
  logic               div_start;
  logic signed [DIV_W-1:0] div_dividend, div_quotient;
  logic [DVS_W-1:0]   div_divisor;
  div_stat_t          div_stat;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    spc_nxt = spc_r;
    cc_nxt  = cc_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_SPC: spc_nxt = pwdata[SPC_W-1:0];
        REG_CC:  cc_nxt  = pwdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SPC: prdata = APB_DW'(spc_r);
      REG_CC:  prdata = APB_DW'(cc_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= SPC_RESET;
      cc_r  <= CC_RESET;
    end else begin
      spc_r <= spc_nxt;
      cc_r  <= cc_nxt;
    end
  end

  // zero counts as one, anything above the maximum saturates
  always_comb begin
    if (spc_r == '0) begin
      ns = NS_W'(1);
    end else if (32'(spc_r) > 32'(MAX_SAMPLES)) begin
      ns = NS_W'(MAX_SAMPLES);
    end else begin
      ns = NS_W'(spc_r);
    end
    if (cc_r == '0) begin
      nc = NC_W'(1);
    end else if (32'(cc_r) > 32'(MAX_CHANNELS)) begin
      nc = NC_W'(MAX_CHANNELS);
    end else begin
      nc = NC_W'(cc_r);
    end
  end

  scm_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .ns     (ns),
    .nc     (nc),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  scm_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  scm_div #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  scm_back #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .JOB_W        (JOB_W),
    .DIV_W        (DIV_W),
    .DVS_W        (DVS_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_stat     (div_stat),
    .div_quotient (div_quotient),
    .out_ch       (out_ch)
  );

  `SCM_ASSERT_IMP(a_no_push_full, q_push, !q_full, "job pushed into a full queue")
  `SCM_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "job popped from an empty queue")
  `SCM_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `SCM_ASSERT_NXT(a_div_runs, div_start, div_stat.busy && !div_stat.done,
                  "divider did not start")

endmodule
